>>> src/sfrp_pkg.sv
// Shared types and constants for the sensor frame record parser.
package sfrp_pkg;

	localparam logic [7:0] MARK_BYTE = 8'hFF;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_RECORD = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	// Width of the packed result payload, rounded up to whole bytes.
	localparam int OUT_DATA_W = 64;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       capture;    // register the accepted input group
		logic       div_start;  // load the divider with code minus one
		logic       div_step;   // one quotient bit
		logic       load;       // write the output register
		logic [1:0] kind;       // kind of the result being written
	} sfrp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic marker;     // captured group is FF FF FF
		logic rec_bad;    // code zero or no ROI count known
		logic div_done;   // the divider is on its last step
		logic out_free;   // the output register can take a result
	} sfrp_sts_t;

endpackage

>>> src/sfrp_dp.sv
// Datapath: input group register, ROI count, 8-bit iterative divider, output register.
module sfrp_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [23:0]                     in_data,
	input  sfrp_pkg::sfrp_cmd_t             cmd,
	output sfrp_pkg::sfrp_sts_t             sts,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      out_kind,
	output logic [sfrp_pkg::OUT_DATA_W-1:0] out_data
);
	import sfrp_pkg::*;

	logic [7:0]  b0_q, b1_q, b2_q;
	logic [7:0]  roi_q;
	logic [7:0]  rem_q, quo_q;
	logic [2:0]  cnt_q;
	logic        valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  act_q, roi_tot_q, sens_q, roi_idx_q;
	logic [11:0] time_q;
	logic [15:0] dist_q;

	logic [8:0]  trial;
	logic        fits;
	logic [11:0] time_scaled;

	assign trial = {rem_q, quo_q[7]};
	assign fits  = (trial >= {1'b0, roi_q});
	// Times ten as eight plus two.
	assign time_scaled = {1'b0, b2_q, 3'b000} + {3'b000, b2_q, 1'b0};

	assign sts.marker   = (b0_q == MARK_BYTE) && (b1_q == MARK_BYTE) && (b2_q == MARK_BYTE);
	assign sts.rec_bad  = (b0_q == 8'd0) || (roi_q == 8'd0);
	assign sts.div_done = (cnt_q == 3'd0);
	assign sts.out_free = !valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			b0_q <= in_data[7:0];
			b1_q <= in_data[15:8];
			b2_q <= in_data[23:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roi_q <= 8'd0;
		end else if (cmd.load && (cmd.kind == KIND_HEADER)) begin
			roi_q <= b1_q;
		end
	end

	// Restoring division, most significant quotient bit first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (cmd.div_start) begin
			cnt_q <= 3'd7;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= 8'd0;
			quo_q <= b0_q - 8'd1;
		end else if (cmd.div_step) begin
			if (fits) begin
				rem_q <= 8'(trial - {1'b0, roi_q});
			end else begin
				rem_q <= trial[7:0];
			end
			quo_q <= {quo_q[6:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q    <= cmd.kind;
			act_q     <= 8'd0;
			roi_tot_q <= 8'd0;
			time_q    <= 12'd0;
			sens_q    <= 8'd0;
			roi_idx_q <= 8'd0;
			dist_q    <= 16'd0;
			case (cmd.kind)
				KIND_HEADER: begin
					act_q     <= b0_q;
					roi_tot_q <= b1_q;
					time_q    <= time_scaled;
				end
				KIND_RECORD: begin
					sens_q    <= quo_q;
					roi_idx_q <= rem_q;
					dist_q    <= {b1_q, b2_q};
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid = valid_q;
	assign out_kind  = kind_q;
	assign out_data  = {4'd0, dist_q, roi_idx_q, sens_q, time_q, roi_tot_q, act_q};

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!valid_q || out_ready))
		else $error("result written over one not yet taken");

	a_div_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> (cnt_q == 3'd7) && (rem_q == 8'd0))
		else $error("divider not loaded");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && (kind_q == KIND_RECORD)) |-> (roi_idx_q < roi_q))
		else $error("ROI index not below ROI count");

endmodule

>>> src/sfrp_ctrl.sv
// Controller: frame phase tracking and sequencing of capture, divide and output.
module sfrp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sfrp_pkg::sfrp_sts_t sts,
	output sfrp_pkg::sfrp_cmd_t cmd
);
	import sfrp_pkg::*;

	typedef enum logic [3:0] {
		ST_TAKE   = 4'b0001,
		ST_DECODE = 4'b0010,
		ST_DIV    = 4'b0100,
		ST_PUT    = 4'b1000
	} state_t;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_SKIP = 4'b0010,
		PH_HEAD = 4'b0100,
		PH_REC  = 4'b1000
	} phase_t;

	state_t     state_q, state_d;
	phase_t     phase_q, phase_d;
	logic [1:0] kind_q, kind_d;

	assign in_ready = (state_q == ST_TAKE);

	always_comb begin
		state_d       = state_q;
		phase_d       = phase_q;
		kind_d        = kind_q;
		cmd.capture   = 1'b0;
		cmd.div_start = 1'b0;
		cmd.div_step  = 1'b0;
		cmd.load      = 1'b0;
		cmd.kind      = kind_q;
		case (state_q)
			ST_TAKE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (phase_q == PH_IDLE) begin
					if (sts.marker) begin
						phase_d = PH_SKIP;
					end
					state_d = ST_TAKE;
				end else if (sts.marker) begin
					phase_d = PH_IDLE;
					kind_d  = KIND_END;
					state_d = ST_PUT;
				end else begin
					case (phase_q)
						PH_SKIP: begin
							phase_d = PH_HEAD;
							state_d = ST_TAKE;
						end
						PH_HEAD: begin
							phase_d = PH_REC;
							kind_d  = KIND_HEADER;
							state_d = ST_PUT;
						end
						default: begin
							if (sts.rec_bad) begin
								kind_d  = KIND_ERROR;
								state_d = ST_PUT;
							end else begin
								kind_d        = KIND_RECORD;
								cmd.div_start = 1'b1;
								state_d       = ST_DIV;
							end
						end
					endcase
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = ST_PUT;
				end
			end
			ST_PUT: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_TAKE;
				end
			end
			default: begin
				state_d = ST_TAKE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_TAKE;
			phase_q <= PH_IDLE;
			kind_q  <= KIND_END;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			kind_q  <= kind_d;
		end
	end

	a_take_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_DECODE))
		else $error("accepted group not decoded");

	a_record_via_div: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && (cmd.kind == KIND_RECORD)) |-> $past(state_q == ST_DIV || state_q == ST_PUT))
		else $error("record written without a division");

	a_phase_rec_after_header: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && (cmd.kind == KIND_HEADER)) |-> (phase_q == PH_REC))
		else $error("header written outside the record phase");

endmodule

>>> src/sensor_frame_record_parser.sv
// Top level of the sensor frame record parser.
//
// Input channel s_*: one request is a 3-byte group from the sensor link.
// A group of FF FF FF opens a frame; the group after it is skipped, the next
// is the header, and each later group is a record until FF FF FF closes the
// frame. Groups outside a frame are dropped.
// Output channel m_*: m_tuser holds the result kind (header, record, frame
// end, record error); m_tdata holds the fields, unused ones zero.
// Each group passes through capture, decode and, for a valid record, an
// 8-bit restoring divider that produces one quotient bit per cycle.
// When a result is written, m_tvalid rises in the same cycle as s_tready
// returns high. The block holds one group at a time: when the receiver
// stalls, a new result waits in the controller until the output register
// is taken, and s_tready stays low meanwhile. Reset clears the frame phase
// to idle, the stored ROI count to zero and the output valid.
module sensor_frame_record_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // first_byte, second_byte, third_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // active_sensors, roi_total, measure_time_us,
	                               // sensor_index, roi_index, distance, 4 zero bits
	output logic [1:0]  m_tuser    // kind
);
	import sfrp_pkg::*;

	sfrp_cmd_t cmd;
	sfrp_sts_t sts;

	sfrp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sfrp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (m_tuser),
		.out_data  (m_tdata)
	);

endmodule
